### hdl/qnl_pkg.sv
// Package for the quaternion normalized linear interpolation block.
// Holds default widths and fixed constants of the normalizing datapath.
// No dependencies.
package qnl_pkg;

  localparam int unsigned CompBitsDef  = 16;
  localparam int unsigned BlendBitsDef = 16;
  localparam int unsigned FifoDepth    = 4;
  localparam int unsigned NormPos      = 29;
  localparam int unsigned UBits        = 30;

endpackage

### hdl/qnl_front.sv
// Front part: takes input transfers, tests the dot product sign and blends.
// Depends on qnl_pkg for default widths.
module qnl_front #(
  parameter int unsigned COMPONENT_BITS = qnl_pkg::CompBitsDef,
  parameter int unsigned BLEND_BITS     = qnl_pkg::BlendBitsDef
) (
  input  logic                                               clk_i,
  input  logic                                               rst_ni,
  input  logic                                               in_valid_i,
  output logic                                               in_ready_o,
  input  logic [3:0][COMPONENT_BITS-1:0]                     first_i,
  input  logic [3:0][COMPONENT_BITS-1:0]                     second_i,
  input  logic [BLEND_BITS:0]                                blend_i,
  output logic                                               out_valid_o,
  input  logic                                               out_ready_i,
  output logic [3:0][COMPONENT_BITS+BLEND_BITS-1:0]          mag_o,
  output logic [3:0]                                         neg_o
);

  localparam int unsigned C = COMPONENT_BITS;
  localparam int unsigned B = BLEND_BITS;
  localparam int unsigned MagBits = C + B;
  localparam int unsigned ProdBits = C + B + 3;
  localparam logic [B:0] BlendOne = (B+1)'(1) << B;

  logic                 adv;
  logic                 f1_valid_q;
  logic [3:0][C-1:0]    a1_q, b1_q;
  logic [B:0]           t1_q;
  logic [3:0][2*C-1:0]  prod1_q;
  logic [3:0][2*C-1:0]  prod_d;
  logic [B:0]           t_sat;

  logic                 f2_valid_q;
  logic [3:0][MagBits-1:0] mag_q, mag_d;
  logic [3:0]           neg_q, neg_d;

  assign adv        = !f2_valid_q || out_ready_i;
  assign in_ready_o = adv;

  always_comb begin
    t_sat = (blend_i > BlendOne) ? BlendOne : blend_i;
    for (int i = 0; i < 4; i++) begin
      prod_d[i] = $signed(first_i[i]) * $signed(second_i[i]);
    end
  end

  always_comb begin
    logic signed [2*C+1:0]     dot;
    logic                      flip;
    logic signed [C:0]         an;
    logic [B:0]                wt;
    logic signed [ProdBits-1:0] pa, pb, v;
    dot = '0;
    for (int i = 0; i < 4; i++) begin
      dot = dot + (2*C+2)'($signed(prod1_q[i]));
    end
    flip = dot[2*C+1];
    wt   = BlendOne - t1_q;
    for (int i = 0; i < 4; i++) begin
      an = flip ? -((C+1)'($signed(a1_q[i]))) : (C+1)'($signed(a1_q[i]));
      pa = an * $signed({1'b0, wt});
      pb = $signed(b1_q[i]) * $signed({1'b0, t1_q});
      v  = pa + pb;
      neg_d[i] = v[ProdBits-1];
      mag_d[i] = v[ProdBits-1] ? MagBits'(-v) : MagBits'(v);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      f1_valid_q <= 1'b0;
      f2_valid_q <= 1'b0;
    end else if (adv) begin
      f1_valid_q <= in_valid_i;
      f2_valid_q <= f1_valid_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      a1_q    <= first_i;
      b1_q    <= second_i;
      t1_q    <= t_sat;
      prod1_q <= prod_d;
      mag_q   <= mag_d;
      neg_q   <= neg_d;
    end
  end

  assign out_valid_o = f2_valid_q;
  assign mag_o       = mag_q;
  assign neg_o       = neg_q;

endmodule

### hdl/qnl_fifo.sv
// Short queue between the front and back parts of the interpolator.
// Depends on qnl_pkg for the default depth.
module qnl_fifo #(
  parameter int unsigned DW    = 8,
  parameter int unsigned DEPTH = qnl_pkg::FifoDepth
) (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          wr_valid_i,
  output logic          wr_ready_o,
  input  logic [DW-1:0] wr_data_i,
  output logic          rd_valid_o,
  input  logic          rd_ready_i,
  output logic [DW-1:0] rd_data_o
);

  localparam int unsigned PW = $clog2(DEPTH);
  localparam int unsigned CW = $clog2(DEPTH + 1);

  logic [DW-1:0] mem_q [DEPTH];
  logic [PW-1:0] wr_ptr_q, rd_ptr_q;
  logic [CW-1:0] cnt_q;
  logic          push, pop;

  assign wr_ready_o = cnt_q != CW'(DEPTH);
  assign rd_valid_o = cnt_q != '0;
  assign push       = wr_valid_i && wr_ready_o;
  assign pop        = rd_valid_o && rd_ready_i;
  assign rd_data_o  = mem_q[rd_ptr_q];

  always_ff @(posedge clk_i) begin
    if (push) begin
      mem_q[wr_ptr_q] <= wr_data_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      if (push) begin
        wr_ptr_q <= (wr_ptr_q == PW'(DEPTH - 1)) ? '0 : wr_ptr_q + PW'(1);
      end
      if (pop) begin
        rd_ptr_q <= (rd_ptr_q == PW'(DEPTH - 1)) ? '0 : rd_ptr_q + PW'(1);
      end
      if (push && !pop) begin
        cnt_q <= cnt_q + CW'(1);
      end else if (pop && !push) begin
        cnt_q <= cnt_q - CW'(1);
      end
    end
  end

endmodule

### hdl/qnl_back.sv
// Back part: normalizes the blended quaternion with a pipelined square root
// and four pipelined dividers. Depends on qnl_pkg for the normalizing constants.
module qnl_back #(
  parameter int unsigned COMPONENT_BITS = qnl_pkg::CompBitsDef,
  parameter int unsigned BLEND_BITS     = qnl_pkg::BlendBitsDef
) (
  input  logic                                        clk_i,
  input  logic                                        rst_ni,
  input  logic                                        in_valid_i,
  output logic                                        in_ready_o,
  input  logic [3:0][COMPONENT_BITS+BLEND_BITS-1:0]   mag_i,
  input  logic [3:0]                                  neg_i,
  output logic                                        out_valid_o,
  input  logic                                        out_ready_i,
  output logic [3:0][COMPONENT_BITS-1:0]              comp_o,
  output logic                                        degenerate_o
);

  localparam int unsigned C    = COMPONENT_BITS;
  localparam int unsigned MW   = COMPONENT_BITS + BLEND_BITS;
  localparam int unsigned LW   = $clog2(MW);
  localparam int unsigned UB   = qnl_pkg::UBits;
  localparam int unsigned SB   = 2 * UB + 2;
  localparam int unsigned NR   = SB / 2;
  localparam int unsigned RB   = NR;
  localparam int unsigned REMW = RB + 3;
  localparam int unsigned F    = C - 2;
  localparam int unsigned QB   = C;
  localparam int unsigned NW   = UB + 1 + F;
  localparam int unsigned DR   = RB + 1;
  localparam logic [QB-1:0] OneF = QB'(1) << F;

  function automatic logic [LW-1:0] lead_pos(input logic [MW-1:0] x);
    logic [LW-1:0] p;
    p = '0;
    for (int i = 0; i < MW; i++) begin
      if (x[i]) p = LW'(i);
    end
    return p;
  endfunction

  logic adv;
  assign adv        = !out_valid_o || out_ready_i;
  assign in_ready_o = adv;

  // Leading one position of the largest magnitude.
  logic [MW-1:0]            mag_or;
  logic                     s1_valid_q, s2_valid_q, s3_valid_q;
  logic [3:0][MW-1:0]       s1_mag_q;
  logic [3:0]               s1_neg_q, s2_neg_q, s3_neg_q;
  logic                     s1_deg_q, s2_deg_q, s3_deg_q;
  logic [LW-1:0]            s1_pos_q;
  logic [3:0][UB-1:0]       u_d, s2_u_q, s3_u_q;
  logic [3:0][2*UB-1:0]     s3_sq_q;
  logic [SB-1:0]            sum_d;

  assign mag_or = mag_i[0] | mag_i[1] | mag_i[2] | mag_i[3];

  always_comb begin
    logic [MW+UB-1:0] wide;
    for (int i = 0; i < 4; i++) begin
      wide = (MW+UB)'(s1_mag_q[i]);
      if (32'(s1_pos_q) > qnl_pkg::NormPos) begin
        wide = wide >> (32'(s1_pos_q) - qnl_pkg::NormPos);
      end else begin
        wide = wide << (qnl_pkg::NormPos - 32'(s1_pos_q));
      end
      u_d[i] = wide[UB-1:0];
    end
    sum_d = SB'(s3_sq_q[0]) + SB'(s3_sq_q[1]) + SB'(s3_sq_q[2]) + SB'(s3_sq_q[3]);
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      s1_mag_q <= mag_i;
      s1_neg_q <= neg_i;
      s1_pos_q <= lead_pos(mag_or);
      s1_deg_q <= ~|mag_or;
      s2_u_q   <= u_d;
      s2_neg_q <= s1_neg_q;
      s2_deg_q <= s1_deg_q;
      for (int i = 0; i < 4; i++) begin
        s3_sq_q[i] <= s2_u_q[i] * s2_u_q[i];
      end
      s3_u_q   <= s2_u_q;
      s3_neg_q <= s2_neg_q;
      s3_deg_q <= s2_deg_q;
    end
  end

  // Square root pipeline, one result bit per stage.
  logic [NR:0]              sr_valid_q;
  logic [REMW-1:0]          sr_rem_q  [NR+1];
  logic [RB-1:0]            sr_root_q [NR+1];
  logic [SB-1:0]            sr_s_q    [NR+1];
  logic [3:0][UB-1:0]       sr_u_q    [NR+1];
  logic [3:0]               sr_neg_q  [NR+1];
  logic                     sr_deg_q  [NR+1];

  always_ff @(posedge clk_i) begin
    if (adv) begin
      sr_rem_q[0]  <= '0;
      sr_root_q[0] <= '0;
      sr_s_q[0]    <= sum_d;
      sr_u_q[0]    <= s3_u_q;
      sr_neg_q[0]  <= s3_neg_q;
      sr_deg_q[0]  <= s3_deg_q;
    end
  end

  for (genvar k = 1; k <= NR; k++) begin : g_sqrt
    logic [REMW-1:0] cur, trial;
    always_comb begin
      cur   = {sr_rem_q[k-1][REMW-3:0], sr_s_q[k-1][SB-1 -: 2]};
      trial = REMW'({sr_root_q[k-1], 2'b01});
    end
    always_ff @(posedge clk_i) begin
      if (adv) begin
        if (cur >= trial) begin
          sr_rem_q[k]  <= cur - trial;
          sr_root_q[k] <= {sr_root_q[k-1][RB-2:0], 1'b1};
        end else begin
          sr_rem_q[k]  <= cur;
          sr_root_q[k] <= {sr_root_q[k-1][RB-2:0], 1'b0};
        end
        sr_s_q[k]   <= sr_s_q[k-1] << 2;
        sr_u_q[k]   <= sr_u_q[k-1];
        sr_neg_q[k] <= sr_neg_q[k-1];
        sr_deg_q[k] <= sr_deg_q[k-1];
      end
    end
  end

  // Restoring dividers, one quotient bit per stage.
  logic [QB:0]              dv_valid_q;
  logic [3:0][DR-1:0]       dv_rem_q  [QB+1];
  logic [3:0][QB-1:0]       dv_lo_q   [QB+1];
  logic [3:0][QB-1:0]       dv_quo_q  [QB+1];
  logic [RB-1:0]            dv_r_q    [QB+1];
  logic [3:0]               dv_neg_q  [QB+1];
  logic                     dv_deg_q  [QB+1];
  logic [3:0][NW-1:0]       num_d;

  always_comb begin
    for (int i = 0; i < 4; i++) begin
      num_d[i] = (NW'(sr_u_q[NR][i]) << F) + NW'(sr_root_q[NR] >> 1);
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      for (int i = 0; i < 4; i++) begin
        dv_rem_q[0][i] <= DR'(num_d[i] >> QB);
        dv_lo_q[0][i]  <= num_d[i][QB-1:0];
      end
      dv_quo_q[0] <= '0;
      dv_r_q[0]   <= sr_root_q[NR];
      dv_neg_q[0] <= sr_neg_q[NR];
      dv_deg_q[0] <= sr_deg_q[NR];
    end
  end

  for (genvar j = 1; j <= QB; j++) begin : g_div
    logic [3:0][DR-1:0] cur;
    logic [3:0]         ge;
    always_comb begin
      for (int i = 0; i < 4; i++) begin
        cur[i] = {dv_rem_q[j-1][i][DR-2:0], dv_lo_q[j-1][i][QB-1]};
        ge[i]  = cur[i] >= DR'(dv_r_q[j-1]);
      end
    end
    always_ff @(posedge clk_i) begin
      if (adv) begin
        for (int i = 0; i < 4; i++) begin
          dv_rem_q[j][i] <= ge[i] ? cur[i] - DR'(dv_r_q[j-1]) : cur[i];
          dv_lo_q[j][i]  <= dv_lo_q[j-1][i] << 1;
          dv_quo_q[j][i] <= {dv_quo_q[j-1][i][QB-2:0], ge[i]};
        end
        dv_r_q[j]   <= dv_r_q[j-1];
        dv_neg_q[j] <= dv_neg_q[j-1];
        dv_deg_q[j] <= dv_deg_q[j-1];
      end
    end
  end

  // Output register.
  logic                 out_valid_q;
  logic [3:0][C-1:0]    comp_q, comp_d;
  logic                 deg_q;

  always_comb begin
    logic [QB-1:0] qc;
    for (int i = 0; i < 4; i++) begin
      qc = (dv_quo_q[QB][i] > OneF) ? OneF : dv_quo_q[QB][i];
      if (dv_deg_q[QB]) begin
        comp_d[i] = '0;
      end else begin
        comp_d[i] = dv_neg_q[QB][i] ? C'(-qc) : C'(qc);
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q  <= 1'b0;
      s2_valid_q  <= 1'b0;
      s3_valid_q  <= 1'b0;
      sr_valid_q  <= '0;
      dv_valid_q  <= '0;
      out_valid_q <= 1'b0;
    end else if (adv) begin
      s1_valid_q  <= in_valid_i;
      s2_valid_q  <= s1_valid_q;
      s3_valid_q  <= s2_valid_q;
      sr_valid_q  <= {sr_valid_q[NR-1:0], s3_valid_q};
      dv_valid_q  <= {dv_valid_q[QB-1:0], sr_valid_q[NR]};
      out_valid_q <= dv_valid_q[QB];
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      comp_q <= comp_d;
      deg_q  <= dv_deg_q[QB];
    end
  end

  assign out_valid_o  = out_valid_q;
  assign comp_o       = comp_q;
  assign degenerate_o = deg_q;

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q && deg_q |-> comp_q == '0)
    else $error("Degenerate result carries nonzero components.");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q && !deg_q |-> comp_q != '0)
    else $error("Nondegenerate result is all zero.");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q |->
      ($signed(comp_q[0]) <= $signed({1'b0, OneF}) &&
       $signed(comp_q[0]) >= -$signed({1'b0, OneF}) &&
       $signed(comp_q[3]) <= $signed({1'b0, OneF}) &&
       $signed(comp_q[3]) >= -$signed({1'b0, OneF})))
    else $error("Result component beyond unit range.");

endmodule

### hdl/quaternion_nlerp.sv
// Top level of the quaternion normalized linear interpolator.
// Depends on qnl_pkg, qnl_front, qnl_fifo and qnl_back.
//
//   channel | direction | handshake               | payload
//   in      | input     | in_valid_i / in_ready_o  | first_*_i, second_*_i, blend_i
//   out     | output    | out_valid_o / out_ready_i| out_*_o, degenerate_o
//
// One transfer per cycle is sustained on both channels while out_ready_i stays high.
// Latency is set by the front registers, the queue and the back pipeline, mostly
// by the 31-step square root pipeline and the one-bit-per-stage dividers.
// Reset clears only the valid flags and the queue pointers and count.
// A stalled output holds the back pipeline; the queue then absorbs the front.
module quaternion_nlerp #(
  parameter int unsigned COMPONENT_BITS = qnl_pkg::CompBitsDef,
  parameter int unsigned BLEND_BITS     = qnl_pkg::BlendBitsDef
) (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  logic                             in_valid_i,
  output logic                             in_ready_o,
  input  logic signed [COMPONENT_BITS-1:0] first_x_i,
  input  logic signed [COMPONENT_BITS-1:0] first_y_i,
  input  logic signed [COMPONENT_BITS-1:0] first_z_i,
  input  logic signed [COMPONENT_BITS-1:0] first_w_i,
  input  logic signed [COMPONENT_BITS-1:0] second_x_i,
  input  logic signed [COMPONENT_BITS-1:0] second_y_i,
  input  logic signed [COMPONENT_BITS-1:0] second_z_i,
  input  logic signed [COMPONENT_BITS-1:0] second_w_i,
  input  logic        [BLEND_BITS:0]       blend_i,
  output logic                             out_valid_o,
  input  logic                             out_ready_i,
  output logic signed [COMPONENT_BITS-1:0] out_x_o,
  output logic signed [COMPONENT_BITS-1:0] out_y_o,
  output logic signed [COMPONENT_BITS-1:0] out_z_o,
  output logic signed [COMPONENT_BITS-1:0] out_w_o,
  output logic                             degenerate_o
);

  localparam int unsigned MW = COMPONENT_BITS + BLEND_BITS;
  localparam int unsigned DW = 4 * MW + 4;

  logic [3:0][COMPONENT_BITS-1:0] first_v, second_v, comp_v;
  logic                           fr_valid, fr_ready;
  logic [3:0][MW-1:0]             fr_mag, bk_mag;
  logic [3:0]                     fr_neg, bk_neg;
  logic                           bk_valid, bk_ready;
  logic [DW-1:0]                  bk_data;

  assign first_v  = {first_w_i, first_z_i, first_y_i, first_x_i};
  assign second_v = {second_w_i, second_z_i, second_y_i, second_x_i};

  qnl_front #(
    .COMPONENT_BITS(COMPONENT_BITS),
    .BLEND_BITS    (BLEND_BITS)
  ) u_front (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_ready_o (in_ready_o),
    .first_i    (first_v),
    .second_i   (second_v),
    .blend_i    (blend_i),
    .out_valid_o(fr_valid),
    .out_ready_i(fr_ready),
    .mag_o      (fr_mag),
    .neg_o      (fr_neg)
  );

  qnl_fifo #(
    .DW   (DW),
    .DEPTH(qnl_pkg::FifoDepth)
  ) u_fifo (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .wr_valid_i(fr_valid),
    .wr_ready_o(fr_ready),
    .wr_data_i ({fr_mag, fr_neg}),
    .rd_valid_o(bk_valid),
    .rd_ready_i(bk_ready),
    .rd_data_o (bk_data)
  );

  assign bk_mag = bk_data[DW-1:4];
  assign bk_neg = bk_data[3:0];

  qnl_back #(
    .COMPONENT_BITS(COMPONENT_BITS),
    .BLEND_BITS    (BLEND_BITS)
  ) u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (bk_valid),
    .in_ready_o  (bk_ready),
    .mag_i       (bk_mag),
    .neg_i       (bk_neg),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .comp_o      (comp_v),
    .degenerate_o(degenerate_o)
  );

  assign out_x_o = comp_v[0];
  assign out_y_o = comp_v[1];
  assign out_z_o = comp_v[2];
  assign out_w_o = comp_v[3];

endmodule

### sim/tb.sv
// Self-checking testbench for quaternion_nlerp: drives random and corner-case
// quaternion pairs and compares each result against a built-in predictor.
// Depends on qnl_pkg and quaternion_nlerp.
`timescale 1ns / 100ps

module tb;

  localparam int unsigned CB = qnl_pkg::CompBitsDef;
  localparam int unsigned BB = qnl_pkg::BlendBitsDef;
  localparam int unsigned FB = CB - 2;
  localparam longint unsigned BlendOne = 64'd1 << BB;
  localparam longint CycleLimit = 400000;

  typedef logic signed [CB-1:0] comp_t;

  typedef struct packed {
    comp_t [3:0] a;
    comp_t [3:0] b;
    logic [BB:0] t;
  } pair_t;

  typedef struct packed {
    comp_t [3:0] q;
    logic        degen;
  } unit_t;

  logic clk, rst_n;
  logic in_valid, in_ready, out_valid, out_ready;
  comp_t fx, fy, fz, fw, sx, sy, sz, sw;
  logic [BB:0] blend;
  comp_t ox, oy, oz, ow;
  logic degen;

  pair_t pending_pairs[$];
  unit_t expected_units[$];
  int send_idle_pct, recv_idle_pct;
  int hold_cycles;
  bit hold_req, hold_done;
  int mismatches;
  longint cycles;
  bit stim_done;

  quaternion_nlerp i_dut (
    .clk_i(clk), .rst_ni(rst_n),
    .in_valid_i(in_valid), .in_ready_o(in_ready),
    .first_x_i(fx), .first_y_i(fy), .first_z_i(fz), .first_w_i(fw),
    .second_x_i(sx), .second_y_i(sy), .second_z_i(sz), .second_w_i(sw),
    .blend_i(blend),
    .out_valid_o(out_valid), .out_ready_i(out_ready),
    .out_x_o(ox), .out_y_o(oy), .out_z_o(oz), .out_w_o(ow),
    .degenerate_o(degen)
  );

  function automatic longint unsigned int_sqrt(longint unsigned x);
    longint unsigned res, bitv;
    res = 0;
    bitv = 64'd1 << 62;
    while (bitv > x) bitv >>= 2;
    while (bitv != 0) begin
      if (x >= res + bitv) begin
        x -= res + bitv;
        res = (res >> 1) + bitv;
      end else begin
        res >>= 1;
      end
      bitv >>= 2;
    end
    return res;
  endfunction

  function automatic unit_t nlerp_unit(pair_t p);
    unit_t u;
    longint av[4], v;
    longint unsigned mag[4], m, sum, r, q, t;
    bit neg[4];
    int right, left;
    logic signed [39:0] dot;
    dot = 0;
    for (int i = 0; i < 4; i++) begin
      av[i] = longint'(p.a[i]);
      dot += 40'(signed'(p.a[i]) * signed'(p.b[i]));
    end
    t = 64'(p.t);
    if (t > BlendOne) t = BlendOne;
    if (dot < 0) for (int i = 0; i < 4; i++) av[i] = -av[i];
    m = 0;
    for (int i = 0; i < 4; i++) begin
      v = av[i] * longint'(BlendOne - t) + longint'(p.b[i]) * longint'(t);
      neg[i] = v < 0;
      mag[i] = neg[i] ? -v : v;
      if (mag[i] > m) m = mag[i];
    end
    u = '0;
    if (m == 0) begin
      u.degen = 1'b1;
      return u;
    end
    right = 0;
    left = 0;
    while (m >= (64'd1 << 30)) begin m >>= 1; right++; end
    while (m < (64'd1 << 29)) begin m <<= 1; left++; end
    sum = 0;
    for (int i = 0; i < 4; i++) begin
      mag[i] = right > 0 ? (mag[i] >> right) : (mag[i] << left);
      sum += mag[i] * mag[i];
    end
    r = int_sqrt(sum);
    for (int i = 0; i < 4; i++) begin
      q = ((mag[i] << FB) + (r >> 1)) / r;
      if (q > (64'd1 << FB)) q = 64'd1 << FB;
      u.q[i] = neg[i] ? comp_t'(-longint'(q)) : comp_t'(q);
    end
    return u;
  endfunction

  function automatic comp_t rand_comp();
    case ($urandom_range(0, 5))
      0: return comp_t'($urandom_range(0, 3) == 0 ? 16'h8000 : 16'h7fff);
      1: return comp_t'($urandom_range(0, 32768) - 16384);
      2: return comp_t'($urandom_range(0, 8) - 4);
      default: return comp_t'($urandom);
    endcase
  endfunction

  function automatic pair_t rand_pair();
    pair_t p;
    for (int i = 0; i < 4; i++) begin
      p.a[i] = rand_comp();
      p.b[i] = $urandom_range(0, 7) == 0 ? p.a[i] : rand_comp();
    end
    if ($urandom_range(0, 15) == 0) p.b = ~p.a + {4{comp_t'(1)}};
    if ($urandom_range(0, 15) == 0) for (int i = 0; i < 4; i++) p.b[i] = -p.a[i];
    case ($urandom_range(0, 5))
      0: p.t = $urandom_range(0, 1) ? '0 : (BB+1)'(BlendOne);
      1: p.t = (BB+1)'($urandom_range(32'(BlendOne), (1 << (BB + 1)) - 1));
      default: p.t = (BB+1)'($urandom_range(0, 32'(BlendOne)));
    endcase
    return p;
  endfunction

  function automatic pair_t make_pair(int a0, int a1, int a2, int a3,
                                      int b0, int b1, int b2, int b3, int t);
    pair_t p;
    p.a = {comp_t'(a3), comp_t'(a2), comp_t'(a1), comp_t'(a0)};
    p.b = {comp_t'(b3), comp_t'(b2), comp_t'(b1), comp_t'(b0)};
    p.t = (BB+1)'(t);
    return p;
  endfunction

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  initial begin
    pair_t p;
    rst_n = 1'b0;
    send_idle_pct = 24;
    recv_idle_pct = 88;
    hold_req = 1'b0;
    stim_done = 1'b0;
    pending_pairs.push_back(make_pair(0, 0, 0, 16384, 0, 0, 0, 16384, 0));
    pending_pairs.push_back(make_pair(0, 0, 0, 0, 0, 0, 0, 0, 32768));
    pending_pairs.push_back(make_pair(16384, 0, 0, 0, -16384, 0, 0, 0, 32768));
    pending_pairs.push_back(make_pair(16384, 0, 0, 0, 0, 16384, 0, 0, 32768));
    pending_pairs.push_back(make_pair(16384, 0, 0, 0, 0, 16384, 0, 0, 65536));
    pending_pairs.push_back(make_pair(16384, 0, 0, 0, 0, 16384, 0, 0, 131071));
    pending_pairs.push_back(make_pair(16384, 0, 0, 0, 0, 16384, 0, 0, 70000));
    pending_pairs.push_back(make_pair(-32768, -32768, -32768, -32768,
                                      -32768, -32768, -32768, -32768, 12345));
    pending_pairs.push_back(make_pair(32767, 32767, 32767, 32767,
                                      -32768, -32768, -32768, -32768, 40000));
    pending_pairs.push_back(make_pair(32767, -32768, 32767, -32768,
                                      -32768, 32767, -32768, 32767, 0));
    pending_pairs.push_back(make_pair(1, 0, 0, 0, 0, 0, 0, 0, 0));
    pending_pairs.push_back(make_pair(0, 0, 0, 0, 0, 0, 0, -1, 65536));
    pending_pairs.push_back(make_pair(1, 0, 0, 0, -1, 0, 0, 0, 32768));
    pending_pairs.push_back(make_pair(1, 1, 0, 0, 1, -1, 0, 0, 32768));
    pending_pairs.push_back(make_pair(16384, 16384, 0, 0, 0, 0, 16384, -16384, 1));
    pending_pairs.push_back(make_pair(5, -7, 3, 2, -4, 6, -1, 9, 65535));
    repeat (5) @(posedge clk);
    rst_n <= 1'b1;
    for (int phase = 0; phase < 3; phase++) begin
      for (int n = 0; n < 500; n++) pending_pairs.push_back(rand_pair());
      if (phase == 0) hold_req = 1'b1;
      while (pending_pairs.size() != 0 || expected_units.size() != 0) @(posedge clk);
      send_idle_pct = phase == 0 ? 88 : 0;
      recv_idle_pct = phase == 0 ? 24 : 0;
    end
    stim_done = 1'b1;
  end

  always @(posedge clk or negedge rst_n) begin
    if (!rst_n) begin
      in_valid <= 1'b0;
      {fx, fy, fz, fw, sx, sy, sz, sw} <= '0;
      blend <= '0;
    end else begin
      pair_t p;
      if (in_valid && in_ready) begin
        expected_units.push_back(nlerp_unit(pending_pairs.pop_front()));
      end
      if ((!in_valid || in_ready) &&
          !(in_valid && in_ready && pending_pairs.size() == 0)) begin
        if (pending_pairs.size() != 0 && $urandom_range(0, 99) >= send_idle_pct) begin
          p = pending_pairs[0];
          in_valid <= 1'b1;
          {fw, fz, fy, fx} <= p.a;
          {sw, sz, sy, sx} <= p.b;
          blend <= p.t;
        end else begin
          in_valid <= 1'b0;
        end
      end else if (in_valid && in_ready) begin
        in_valid <= 1'b0;
      end
    end
  end

  always @(posedge clk or negedge rst_n) begin
    if (!rst_n) begin
      out_ready <= 1'b0;
      hold_cycles <= 0;
      hold_done <= 1'b0;
    end else if (hold_req && !hold_done) begin
      hold_cycles <= 400;
      hold_done <= 1'b1;
      out_ready <= 1'b0;
    end else if (hold_cycles > 0) begin
      hold_cycles <= hold_cycles - 1;
      out_ready <= 1'b0;
    end else begin
      out_ready <= $urandom_range(0, 99) >= recv_idle_pct;
    end
  end

  always @(posedge clk or negedge rst_n) begin
    if (!rst_n) begin
      mismatches <= 0;
    end else if (out_valid && out_ready) begin
      unit_t want, got;
      got.q = {ow, oz, oy, ox};
      got.degen = degen;
      if (expected_units.size() == 0) begin
        if (mismatches < 10) $display("unexpected transfer: %p", got);
        mismatches <= mismatches + 1;
      end else begin
        want = expected_units.pop_front();
        if (want !== got) begin
          if (mismatches < 10) begin
            $display("mismatch: expected x=%0d y=%0d z=%0d w=%0d degenerate=%0b",
                     want.q[0], want.q[1], want.q[2], want.q[3], want.degen);
            $display("          actual   x=%0d y=%0d z=%0d w=%0d degenerate=%0b",
                     got.q[0], got.q[1], got.q[2], got.q[3], got.degen);
          end
          mismatches <= mismatches + 1;
        end
      end
    end
  end

  initial begin
    cycles = 0;
    while (!stim_done && cycles < CycleLimit) begin
      @(posedge clk);
      cycles++;
    end
    if (cycles >= CycleLimit) begin
      $display("tb: failure");
    end else begin
      repeat (CB + 60) @(posedge clk);
      if (mismatches == 0 && expected_units.size() == 0) begin
        $display("tb: success");
      end else begin
        $display("tb: failure");
      end
    end
    $finish;
  end

endmodule
